// File: src/sfrd_pkg.sv
// shared types and constants for the start-of-frame receiver with command dispatch
// no dependencies; used by sfrd_parse and sof_frame_receiver_dispatch
package sfrd_pkg;

  localparam logic [7:0] START_RESET = 8'h41;
  localparam logic [7:0] CMD_LED_A   = 8'h31;
  localparam logic [7:0] CMD_LED_B   = 8'hD2;

  localparam int unsigned RES_TDATA_W = 64;

  typedef enum logic [3:0] {
    PH_HUNT   = 4'b0001,
    PH_CMD    = 4'b0010,
    PH_CONFIG = 4'b0100,
    PH_DATA   = 4'b1000
  } phase_t;

  typedef struct packed {
    logic        frame_done;
    logic [7:0]  frame_cmd;
    logic [15:0] frame_config;
    logic [31:0] frame_data;
    logic        ack_request;
    logic        led_a_level;
    logic        led_b_level;
    logic        byte_dropped;
  } result_t;

endpackage

// File: src/sfrd_parse.sv
// frame parser: hunt state, byte gathering, command dispatch and led levels
// depends on sfrd_pkg
module sfrd_parse (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         rx_byte,
  input  logic [7:0]         start_byte,
  output sfrd_pkg::result_t  result
);

  sfrd_pkg::phase_t phase, phase_next;
  logic [1:0]       byte_index, byte_index_next;
  logic [7:0]       held_cmd, held_cmd_next;
  logic [15:0]      held_config, held_config_next;
  logic [31:0]      held_data, held_data_next;
  logic             led_a, led_a_next;
  logic             led_b, led_b_next;
  logic             done;
  logic             ack;
  logic             dropped;

  always_comb begin
    phase_next       = phase;
    byte_index_next  = byte_index;
    held_cmd_next    = held_cmd;
    held_config_next = held_config;
    held_data_next   = held_data;
    led_a_next       = led_a;
    led_b_next       = led_b;
    done             = 1'b0;
    ack              = 1'b0;
    dropped          = 1'b0;
    case (phase)
      sfrd_pkg::PH_CMD: begin
        held_cmd_next   = rx_byte;
        byte_index_next = 2'd0;
        phase_next      = sfrd_pkg::PH_CONFIG;
      end
      sfrd_pkg::PH_CONFIG: begin
        if (byte_index == 2'd0) begin
          held_config_next = {8'h00, rx_byte};
          byte_index_next  = 2'd1;
        end else begin
          held_config_next = {rx_byte, held_config[7:0]};
          byte_index_next  = 2'd0;
          phase_next       = sfrd_pkg::PH_DATA;
        end
      end
      sfrd_pkg::PH_DATA: begin
        case (byte_index)
          2'd0:    held_data_next = {24'h000000, rx_byte};
          2'd1:    held_data_next = {held_data[31:16], rx_byte, held_data[7:0]};
          2'd2:    held_data_next = {held_data[31:24], rx_byte, held_data[15:0]};
          default: held_data_next = {rx_byte, held_data[23:0]};
        endcase
        if (byte_index == 2'd3) begin
          done            = 1'b1;
          byte_index_next = 2'd0;
          phase_next      = sfrd_pkg::PH_HUNT;
          if (held_cmd == sfrd_pkg::CMD_LED_A) begin
            led_a_next = ~led_a;
            ack        = 1'b1;
          end else if (held_cmd == sfrd_pkg::CMD_LED_B) begin
            led_b_next = ~led_b;
            ack        = 1'b1;
          end
        end else begin
          byte_index_next = byte_index + 2'd1;
        end
      end
      default: begin
        if (rx_byte == start_byte) begin
          phase_next = sfrd_pkg::PH_CMD;
        end else begin
          phase_next = sfrd_pkg::PH_HUNT;
          dropped    = 1'b1;
        end
        byte_index_next = 2'd0;
      end
    endcase
  end

  always_comb begin
    result.frame_done   = done;
    result.frame_cmd    = done ? held_cmd : 8'h00;
    result.frame_config = done ? held_config : 16'h0000;
    result.frame_data   = done ? held_data_next : 32'h0;
    result.ack_request  = ack;
    result.led_a_level  = led_a_next;
    result.led_b_level  = led_b_next;
    result.byte_dropped = dropped;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= sfrd_pkg::PH_HUNT;
      byte_index  <= 2'd0;
      held_cmd    <= 8'h00;
      held_config <= 16'h0000;
      held_data   <= 32'h0;
      led_a       <= 1'b0;
      led_b       <= 1'b0;
    end else if (accept) begin
      phase       <= phase_next;
      byte_index  <= byte_index_next;
      held_cmd    <= held_cmd_next;
      held_config <= held_config_next;
      held_data   <= held_data_next;
      led_a       <= led_a_next;
      led_b       <= led_b_next;
    end
  end

endmodule

// File: src/sof_frame_receiver_dispatch.sv
// each accepted byte's result is registered in the output register, or in the skid register while the output is stalled
// throughput: one byte per cycle while s_tready is high; the parser state updates in the accepting cycle
// a skid register takes one more result while the output is stalled, then input stalls
// reset (rst, synchronous): hunting for start byte, gathered bytes and leds cleared,
// start byte back to 0x41, output and skid registers empty
module sof_frame_receiver_dispatch (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic        m_tlast,   // frame_done
  // frame_cmd, frame_config, frame_data, ack_request, led_a_level, led_b_level,
  // byte_dropped, zero pad
  output logic [sfrd_pkg::RES_TDATA_W-1:0] m_tdata
);

  logic              [7:0] start_byte;
  logic                    accept;
  sfrd_pkg::result_t       new_res;
  sfrd_pkg::result_t       out_res;
  sfrd_pkg::result_t       skid_res;
  logic                    out_valid;
  logic                    skid_valid;

  assign s_tready = ~skid_valid;
  assign accept   = s_tvalid & s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      start_byte <= sfrd_pkg::START_RESET;
    end else if (cfg_we) begin
      start_byte <= cfg_wdata;
    end
  end

  sfrd_parse u_parse (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .rx_byte    (s_tdata),
    .start_byte (start_byte),
    .result     (new_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!out_valid || m_tready) begin
      out_valid  <= skid_valid | accept;
      skid_valid <= 1'b0;
    end else if (accept) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_valid || m_tready) begin
      out_res <= skid_valid ? skid_res : new_res;
    end
    if (out_valid && !m_tready && accept) begin
      skid_res <= new_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tlast  = out_res.frame_done;
  assign m_tdata  = {4'h0, out_res.byte_dropped, out_res.led_b_level, out_res.led_a_level,
                     out_res.ack_request, out_res.frame_data, out_res.frame_config,
                     out_res.frame_cmd};

endmodule

// File: src/sfrd_check.sv
// port-level checks for sof_frame_receiver_dispatch, attached by bind
// depends on sfrd_pkg for the result width
module sfrd_check (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_tvalid,
  input logic                             s_tready,
  input logic                             m_tvalid,
  input logic                             m_tready,
  input logic                             m_tlast,
  input logic [sfrd_pkg::RES_TDATA_W-1:0] m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result transfer withdrawn while stalled");

  a_reset_empty: assert property (@(posedge clk)
    $past(rst) |-> !m_tvalid)
    else $error("result valid right after reset");

  a_no_frame_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> m_tdata[56:0] == 57'h0)
    else $error("frame fields or ack set without a completed frame");

  a_drop_not_done: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tdata[59])
    else $error("byte dropped on the byte that completed a frame");

  a_led_steady: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast ##1 m_tvalid && !m_tlast
      |-> m_tdata[58:57] == $past(m_tdata[58:57]))
    else $error("led level changed without a completed frame");

endmodule

bind sof_frame_receiver_dispatch sfrd_check u_sfrd_check (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tlast  (m_tlast),
  .m_tdata  (m_tdata)
);

// File: verif/tb_sof_frame_receiver_dispatch.sv
// testbench for sof_frame_receiver_dispatch: directed frames, start byte changes, random traffic
// with random and long output stalls; results checked against a parser mirror kept here
// depends on sfrd_pkg and the sof_frame_receiver_dispatch rtl
module tb_sof_frame_receiver_dispatch;

  localparam int LIMIT_CYCLES = 300000;
  localparam int ITEMS_PER_PHASE = 105;
  localparam logic [7:0] CMD_OTHER_D3 = 8'hD3;
  localparam logic [7:0] CMD_OTHER_D4 = 8'hD4;
  localparam logic [7:0] CMD_OTHER_20 = 8'h20;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [7:0] cfg_wdata = 8'h00;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = 8'h00;  // rx_byte
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic m_tlast;                // frame_done
  // frame_cmd, frame_config, frame_data, ack_request, led_a_level, led_b_level,
  // byte_dropped, zero pad
  logic [sfrd_pkg::RES_TDATA_W-1:0] m_tdata;

  // parser mirror
  logic [7:0] start_val = sfrd_pkg::START_RESET;
  sfrd_pkg::phase_t parse_phase = sfrd_pkg::PH_HUNT;
  logic [1:0] word_pos = 2'd0;
  logic [7:0] held_cmd = 8'h00;
  logic [15:0] held_config = 16'h0000;
  logic [31:0] held_data = 32'h0;
  logic led_a = 1'b0;
  logic led_b = 1'b0;

  sfrd_pkg::result_t pending_reports[$];
  int mismatch_count = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_left = 0;

  sof_frame_receiver_dispatch dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tlast  (m_tlast),
    .m_tdata  (m_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  // output side: random stalls, or a counted hold-off
  always @(posedge clk) begin
    if (hold_left > 0) begin
      m_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else begin
      m_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  function automatic sfrd_pkg::result_t advance_parser(input logic [7:0] b);
    sfrd_pkg::result_t r;
    r = '0;
    case (parse_phase)
      sfrd_pkg::PH_HUNT: begin
        if (b == start_val) parse_phase = sfrd_pkg::PH_CMD;
        else r.byte_dropped = 1'b1;
        word_pos = 2'd0;
      end
      sfrd_pkg::PH_CMD: begin
        held_cmd = b;
        word_pos = 2'd0;
        parse_phase = sfrd_pkg::PH_CONFIG;
      end
      sfrd_pkg::PH_CONFIG: begin
        if (word_pos == 2'd0) begin
          held_config = {8'h00, b};
          word_pos = 2'd1;
        end else begin
          held_config[15:8] = b;
          word_pos = 2'd0;
          parse_phase = sfrd_pkg::PH_DATA;
        end
      end
      default: begin
        if (word_pos == 2'd0) held_data = {24'h0, b};
        else held_data[8*word_pos +: 8] = b;
        if (word_pos == 2'd3) begin
          r.frame_done = 1'b1;
          r.frame_cmd = held_cmd;
          r.frame_config = held_config;
          r.frame_data = held_data;
          word_pos = 2'd0;
          parse_phase = sfrd_pkg::PH_HUNT;
          if (held_cmd == sfrd_pkg::CMD_LED_A) begin
            led_a = ~led_a;
            r.ack_request = 1'b1;
          end else if (held_cmd == sfrd_pkg::CMD_LED_B) begin
            led_b = ~led_b;
            r.ack_request = 1'b1;
          end
        end else begin
          word_pos = word_pos + 2'd1;
        end
      end
    endcase
    r.led_a_level = led_a;
    r.led_b_level = led_b;
    return r;
  endfunction

  function automatic logic [7:0] pick_cmd();
    case ($urandom_range(5))
      0: return sfrd_pkg::CMD_LED_A;
      1: return sfrd_pkg::CMD_LED_B;
      2: return CMD_OTHER_D3;
      3: return CMD_OTHER_D4;
      4: return CMD_OTHER_20;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    sfrd_pkg::result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_reports.size() == 0) begin
        report_mismatch("transfer with nothing pending", m_tdata, 64'h0);
      end else begin
        want = pending_reports.pop_front();
        if (m_tlast !== want.frame_done)
          report_mismatch("frame_done", 64'(m_tlast), 64'(want.frame_done));
        if (m_tdata[7:0] !== want.frame_cmd)
          report_mismatch("frame_cmd", 64'(m_tdata[7:0]), 64'(want.frame_cmd));
        if (m_tdata[23:8] !== want.frame_config)
          report_mismatch("frame_config", 64'(m_tdata[23:8]), 64'(want.frame_config));
        if (m_tdata[55:24] !== want.frame_data)
          report_mismatch("frame_data", 64'(m_tdata[55:24]), 64'(want.frame_data));
        if (m_tdata[56] !== want.ack_request)
          report_mismatch("ack_request", 64'(m_tdata[56]), 64'(want.ack_request));
        if (m_tdata[57] !== want.led_a_level)
          report_mismatch("led_a_level", 64'(m_tdata[57]), 64'(want.led_a_level));
        if (m_tdata[58] !== want.led_b_level)
          report_mismatch("led_b_level", 64'(m_tdata[58]), 64'(want.led_b_level));
        if (m_tdata[59] !== want.byte_dropped)
          report_mismatch("byte_dropped", 64'(m_tdata[59]), 64'(want.byte_dropped));
        if (m_tdata[63:60] !== 4'h0)
          report_mismatch("pad", 64'(m_tdata[63:60]), 64'h0);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      s_tdata <= 8'($urandom);
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= b;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_reports.push_back(advance_parser(b));
    bytes_sent++;
  endtask

  task automatic send_frame(input logic [7:0] cmd, input logic [15:0] cfg,
                            input logic [31:0] data);
    send_byte(start_val);
    send_byte(cmd);
    send_byte(cfg[7:0]);
    send_byte(cfg[15:8]);
    for (int i = 0; i < 4; i++) send_byte(data[8*i +: 8]);
  endtask

  task automatic wait_quiet();
    s_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_start(input logic [7:0] v);
    wait_quiet();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    start_val = v;
  endtask

  task automatic test_directed();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(sfrd_pkg::CMD_LED_A, 16'hFFFF, 32'hFFFF_FFFF);
    // start byte inside the payload is plain data
    send_frame(sfrd_pkg::CMD_LED_B, {2{sfrd_pkg::START_RESET}}, {4{sfrd_pkg::START_RESET}});
    send_frame(CMD_OTHER_D4, 16'h0000, 32'h0);
  endtask

  task automatic test_start_byte();
    write_start(8'h00);
    send_byte(sfrd_pkg::START_RESET);
    send_frame(CMD_OTHER_D3, 16'h1234, 32'h89AB_CDEF);
    write_start(8'hFF);
    send_frame(sfrd_pkg::CMD_LED_A, 16'h00FF, 32'h8000_0001);
    // change in the middle of a frame, new value only at the next hunt
    send_byte(start_val);
    send_byte(CMD_OTHER_20);
    send_byte(8'h5A);
    write_start(8'h7E);
    for (int i = 0; i < 5; i++) send_byte(8'($urandom));
    send_byte(8'hFF);
    send_frame(sfrd_pkg::CMD_LED_B, 16'hA55A, 32'h0F0F_F0F0);
    write_start(sfrd_pkg::START_RESET);
  endtask

  task automatic test_random_traffic();
    int idle_tbl[4] = '{0, 59, 0, 16};
    int stall_tbl[4] = '{0, 0, 59, 16};
    int goal;
    int pick;
    int extra;
    for (int p = 0; p < 4; p++) begin
      if ($urandom_range(2) == 0) write_start(8'($urandom));
      else write_start(sfrd_pkg::START_RESET);
      send_idle_pct = idle_tbl[p];
      stall_pct = stall_tbl[p];
      goal = bytes_sent + ITEMS_PER_PHASE;
      while (bytes_sent < goal) begin
        pick = $urandom_range(99);
        if (pick < 75) begin
          send_frame(pick_cmd(), 16'($urandom), $urandom);
        end else if (pick < 85) begin
          // cut-off frame
          send_byte(start_val);
          send_byte(pick_cmd());
          extra = $urandom_range(4);
          for (int i = 0; i < extra; i++) send_byte(8'($urandom));
        end else begin
          send_byte(8'($urandom));
        end
      end
    end
    send_idle_pct = 0;
    stall_pct = 0;
  endtask

  task automatic test_backpressure();
    wait_quiet();
    hold_left = 250;
    for (int i = 0; i < 5; i++) send_frame(pick_cmd(), 16'($urandom), $urandom);
    wait_quiet();
    stall_pct = 30;
    send_idle_pct = 30;
    for (int i = 0; i < 3; i++) send_frame(pick_cmd(), 16'($urandom), $urandom);
    wait_quiet();
    stall_pct = 0;
    send_idle_pct = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_start_byte();
    test_random_traffic();
    test_backpressure();
    wait_quiet();
    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_reports.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
